>>> design/fsq_pkg.sv
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types, codes and defaults for the subscriber queue fan-out block.
// ----------------------------------------------------------------------------
package fsq_pkg;

    localparam int MAX_SUBSCRIBERS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 16;

    localparam logic FUNC_PUBLISH = 1'b0;
    localparam logic FUNC_GET     = 1'b1;

    typedef enum logic [2:0] {
        ST_MESSAGE    = 3'd0,
        ST_SUBSCRIBED = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_FULL_TABLE = 3'd3,
        ST_PUBLISHED  = 3'd4,
        ST_PUB_DROPS  = 3'd5
    } status_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
        logic signed [31:0] subscriber;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] data;
        status_t            status;
    } rsp_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    start;
        logic    eval_en;
        logic    scan_stop;
        logic    status_load;
        status_t status;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ev_valid;
        logic is_get;
        logic match;
        logic fill_zero;
        logic ev_last;
        logic free_avail;
        logic drop_any;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/fsq_ctrl.sv
// ----------------------------------------------------------------------------
// fsq_ctrl
// Sequencer that runs the table scan for one beat and picks its status.
// ----------------------------------------------------------------------------
module fsq_ctrl
    import fsq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status      = ST_PUBLISHED;
        req_stall       = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.eval_en = 1'b1;
                if (st.ev_valid)
                begin
                    if (st.is_get && st.match)
                    begin
                        cmd.status_load = 1'b1;
                        cmd.scan_stop   = 1'b1;
                        cmd.status      = st.fill_zero ? ST_EMPTY : ST_MESSAGE;
                        state_next      = S_EMIT;
                    end
                    else if (st.ev_last)
                    begin
                        cmd.status_load = 1'b1;
                        if (st.is_get)
                        begin
                            cmd.status = st.free_avail ? ST_SUBSCRIBED : ST_FULL_TABLE;
                        end
                        else
                        begin
                            cmd.status = st.drop_any ? ST_PUB_DROPS : ST_PUBLISHED;
                        end
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/fsq_dpath.sv
// ----------------------------------------------------------------------------
// fsq_dpath
// Subscriber table, queue memory, scan pipeline and result register.
// ----------------------------------------------------------------------------
module fsq_dpath
    import fsq_pkg::*;
#(
    parameter int MAX_SUBSCRIBERS = MAX_SUBSCRIBERS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_item_t  req,
    output rsp_item_t  rsp,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  ctrl_cmd_t  cmd,
    output dp_status_t st
);

    localparam int IDX_W     = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
    localparam int HEAD_W    = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = HEAD_W + 1;
    localparam int MEM_DEPTH = MAX_SUBSCRIBERS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_SUBSCRIBERS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    logic [MAX_SUBSCRIBERS-1:0] entry_valid_reg;
    logic [31:0]                entry_key_reg  [MAX_SUBSCRIBERS];
    logic [HEAD_W-1:0]          head_reg       [MAX_SUBSCRIBERS];
    logic [FILL_W-1:0]          fill_reg       [MAX_SUBSCRIBERS];
    logic [31:0]                queue_mem      [MEM_DEPTH];

    logic              func_reg;
    logic [31:0]       value_reg;
    logic [31:0]       key_reg;

    logic              rd_busy_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              ev_valid_reg;
    logic [IDX_W-1:0]  ev_idx_reg;
    logic              q_valid_reg;
    logic [31:0]       q_key_reg;
    logic [HEAD_W-1:0] q_head_reg;
    logic [FILL_W-1:0] q_fill_reg;

    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              drop_reg;

    logic [31:0]       mem_rd_reg;
    status_t           res_status_reg;
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;
    status_t           out_status_reg;

    logic              eval_fire;
    logic              match;
    logic              q_full;
    logic              free_avail;
    logic              do_push;
    logic              do_pop;
    logic              do_sub;
    logic [IDX_W-1:0]  sub_idx;
    logic [SUM_W-1:0]  push_sum;
    logic [SUM_W-1:0]  push_wrap;
    logic [SUM_W-1:0]  head_inc;
    logic [HEAD_W-1:0] head_next;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] push_addr;
    logic [ADDR_W-1:0] pop_addr;

    assign eval_fire  = cmd.eval_en && ev_valid_reg;
    assign match      = q_valid_reg && (q_key_reg == key_reg);
    assign q_full     = (q_fill_reg == FILL_FULL);
    assign free_avail = free_found_reg || !q_valid_reg;
    assign sub_idx    = free_found_reg ? free_idx_reg : ev_idx_reg;

    assign do_push = eval_fire && (func_reg == FUNC_PUBLISH) && q_valid_reg && !q_full;
    assign do_pop  = eval_fire && (func_reg == FUNC_GET) && match
                     && (q_fill_reg != '0);
    assign do_sub  = eval_fire && (func_reg == FUNC_GET) && !match
                     && (ev_idx_reg == LAST_IDX) && free_avail;

    // The write slot is head plus fill, which stays below twice the depth.
    assign push_sum  = SUM_W'(q_head_reg) + SUM_W'(q_fill_reg);
    assign push_wrap = (push_sum >= DEPTH_SUM) ? (push_sum - DEPTH_SUM) : push_sum;
    assign head_inc  = SUM_W'(q_head_reg) + SUM_W'(1);
    assign head_next = (head_inc == DEPTH_SUM) ? '0 : head_inc[HEAD_W-1:0];

    assign base_addr = ADDR_W'(ev_idx_reg) * ADDR_W'(QUEUE_DEPTH);
    assign push_addr = base_addr + ADDR_W'(push_wrap[HEAD_W-1:0]);
    assign pop_addr  = base_addr + ADDR_W'(q_head_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_busy_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            ev_valid_reg    <= 1'b0;
            free_found_reg  <= 1'b0;
            drop_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                rd_busy_reg    <= 1'b1;
                rd_idx_reg     <= '0;
                ev_valid_reg   <= 1'b0;
                free_found_reg <= 1'b0;
                drop_reg       <= 1'b0;
            end
            else
            begin
                ev_valid_reg <= rd_busy_reg && !cmd.scan_stop;
                if (cmd.scan_stop)
                begin
                    rd_busy_reg <= 1'b0;
                end
                else if (rd_busy_reg)
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        rd_busy_reg <= 1'b0;
                    end
                end
                if (eval_fire && !q_valid_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (eval_fire && (func_reg == FUNC_PUBLISH) && q_valid_reg && q_full)
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (do_sub)
            begin
                entry_valid_reg[sub_idx] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg  <= req.func;
            value_reg <= req.value;
            key_reg   <= req.subscriber;
        end
        if (rd_busy_reg)
        begin
            ev_idx_reg  <= rd_idx_reg;
            q_valid_reg <= entry_valid_reg[rd_idx_reg];
            q_key_reg   <= entry_key_reg[rd_idx_reg];
            q_head_reg  <= head_reg[rd_idx_reg];
            q_fill_reg  <= fill_reg[rd_idx_reg];
        end
        if (eval_fire && !q_valid_reg && !free_found_reg)
        begin
            free_idx_reg <= ev_idx_reg;
        end
        if (do_push)
        begin
            fill_reg[ev_idx_reg] <= q_fill_reg + FILL_W'(1);
        end
        if (do_pop)
        begin
            head_reg[ev_idx_reg] <= head_next;
            fill_reg[ev_idx_reg] <= q_fill_reg - FILL_W'(1);
        end
        if (do_sub)
        begin
            entry_key_reg[sub_idx] <= key_reg;
            head_reg[sub_idx]      <= '0;
            fill_reg[sub_idx]      <= '0;
        end
        if (cmd.status_load)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= (res_status_reg == ST_MESSAGE) ? mem_rd_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_mem[push_addr] <= value_reg;
        end
        if (do_pop)
        begin
            mem_rd_reg <= queue_mem[pop_addr];
        end
    end

    assign st.ev_valid   = ev_valid_reg;
    assign st.is_get     = (func_reg == FUNC_GET);
    assign st.match      = match;
    assign st.fill_zero  = (q_fill_reg == '0);
    assign st.ev_last    = (ev_idx_reg == LAST_IDX);
    assign st.free_avail = free_avail;
    assign st.drop_any   = drop_reg || (q_valid_reg && q_full);
    assign st.out_free   = !out_valid_reg || !rsp_stall;

    assign rsp_valid   = out_valid_reg;
    assign rsp.data    = out_data_reg;
    assign rsp.status  = out_status_reg;

endmodule

>>> design/fanout_subscriber_queues.sv
// ----------------------------------------------------------------------------
// fanout_subscriber_queues
// One topic fanned out into a bounded FIFO queue per subscriber.
// ----------------------------------------------------------------------------
// A request beat on req carries either a publish, whose value is appended to
// the queue of every subscriber that has room, or a get, which pops the head
// of the named subscriber's queue or subscribes an unknown key. Every request
// beat yields exactly one response beat on rsp with a data word and a status.
// The block scans the subscriber table one slot per cycle through a
// registered read; a get that matches the key in a slot stops the scan
// there, and a get with an unknown key scans the whole table like a publish.
// The queue memory has one write and one read port; a publish writes one
// entry per scanned subscriber whose queue is not full. One request is
// worked on at a time, and req_stall is high from accept until the response
// is loaded into the output register. A stalled response holds in that
// register while the block goes back to accepting the next request. Reset
// empties the subscriber table and clears both channels; no clearing pass
// over the memories is needed.
// ----------------------------------------------------------------------------
module fanout_subscriber_queues
    import fsq_pkg::*;
#(
    parameter int MAX_SUBSCRIBERS = MAX_SUBSCRIBERS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    fsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    fsq_dpath #(
        .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

>>> verif/fsq_checker.sv
// ----------------------------------------------------------------------------
// fsq_checker
// Scoreboard for the subscriber queue fan-out block.
// ----------------------------------------------------------------------------
// Every accepted request beat is run through a cycle-free model of the
// subscriber table and its queues. The response it should produce is queued.
// Every accepted response beat is compared field by field against the oldest
// queued response. The mismatch count and the number of responses still owed
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module fsq_checker
    import fsq_pkg::*;
#(
    parameter int MAX_SUBSCRIBERS = MAX_SUBSCRIBERS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp,
    output int        errors,
    output int        pending
);

    logic        sub_used  [MAX_SUBSCRIBERS];
    logic [31:0] sub_key   [MAX_SUBSCRIBERS];
    logic [31:0] msg_ring  [MAX_SUBSCRIBERS][QUEUE_DEPTH];
    int unsigned ring_head [MAX_SUBSCRIBERS];
    int unsigned ring_fill [MAX_SUBSCRIBERS];
    rsp_item_t   owed_rsp  [$];
    int          fault_count;

    function automatic rsp_item_t serve_request(req_item_t it);
        rsp_item_t r;
        logic      dropped;
        r.data   = '0;
        r.status = ST_PUBLISHED;
        if (it.func == FUNC_PUBLISH)
        begin
            dropped = 1'b0;
            for (int s = 0; s < MAX_SUBSCRIBERS; s++)
            begin
                if (sub_used[s])
                begin
                    if (ring_fill[s] >= QUEUE_DEPTH)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        msg_ring[s][(ring_head[s] + ring_fill[s]) % QUEUE_DEPTH] = it.value;
                        ring_fill[s]++;
                    end
                end
            end
            r.status = dropped ? ST_PUB_DROPS : ST_PUBLISHED;
            return r;
        end
        for (int s = 0; s < MAX_SUBSCRIBERS; s++)
        begin
            if (sub_used[s] && sub_key[s] == it.subscriber)
            begin
                if (ring_fill[s] == 0)
                begin
                    r.status = ST_EMPTY;
                    return r;
                end
                r.data       = msg_ring[s][ring_head[s]];
                r.status     = ST_MESSAGE;
                ring_head[s] = (ring_head[s] + 1) % QUEUE_DEPTH;
                ring_fill[s]--;
                return r;
            end
        end
        for (int s = 0; s < MAX_SUBSCRIBERS; s++)
        begin
            if (!sub_used[s])
            begin
                sub_used[s]  = 1'b1;
                sub_key[s]   = it.subscriber;
                ring_head[s] = 0;
                ring_fill[s] = 0;
                r.status     = ST_SUBSCRIBED;
                return r;
            end
        end
        r.status = ST_FULL_TABLE;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SUBSCRIBERS; s++)
            begin
                sub_used[s]  = 1'b0;
                sub_key[s]   = '0;
                ring_head[s] = 0;
                ring_fill[s] = 0;
            end
            owed_rsp.delete();
            fault_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("unexpected response beat: data %h status %0d",
                                 rsp.data, rsp.status);
                    end
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    if (rsp.data !== want.data || rsp.status !== want.status)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("response mismatch: expected data %h status %0d, got data %h status %0d",
                                     want.data, want.status, rsp.data, rsp.status);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                owed_rsp.push_back(serve_request(req));
            end
            errors  <= fault_count;
            pending <= owed_rsp.size();
        end
    end

endmodule

>>> verif/fanout_subscriber_queues_tb.sv
// ----------------------------------------------------------------------------
// fanout_subscriber_queues_tb
// Testbench top for the subscriber queue fan-out block.
// ----------------------------------------------------------------------------
// A short directed sequence covers publishing with no subscribers, the key
// and value extremes, empty queues and a full subscriber table. Random phases
// follow with publish-heavy and get-heavy mixes so that queues overflow, drain
// and wrap. Both channels idle in random bursts except in the final phase.
// Checking is done by fsq_checker, which runs beside the block.
// ----------------------------------------------------------------------------
module fanout_subscriber_queues_tb;
    import fsq_pkg::*;

    localparam int PHASE_COUNT  = 9;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    int          errors;
    int          pending;
    int          cycles     = 0;
    int          req_odds   = 0;
    int          stall_odds = 0;
    int          stall_left = 0;
    logic [31:0] known_keys [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                                    32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004};

    fanout_subscriber_queues i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    fsq_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || stall_odds == 0)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            rsp_stall  <= 1'b0;
        end
        else if ($urandom_range(1, 100) <= stall_odds)
        begin
            stall_left <= $urandom_range(1, 4);
            rsp_stall  <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_value();
        logic [31:0] extremes [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        if ($urandom_range(0, 7) == 0)
        begin
            return extremes[$urandom_range(0, 3)];
        end
        return $urandom;
    endfunction

    function automatic req_item_t make_publish(logic [31:0] val);
        req_item_t it;
        it.func       = FUNC_PUBLISH;
        it.value      = val;
        it.subscriber = $urandom;
        return it;
    endfunction

    function automatic req_item_t make_get(logic [31:0] key);
        req_item_t it;
        it.func       = FUNC_GET;
        it.value      = $urandom;
        it.subscriber = key;
        return it;
    endfunction

    task automatic send_beat(input req_item_t it);
        int gap;
        if (req_odds != 0 && $urandom_range(1, 100) <= req_odds)
        begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int publish_pct;
        int odds_choice [3] = '{0, 20, 50};
        int mix_choice  [4] = '{3, 10, 50, 85};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(make_publish(32'h1234_5678));
        send_beat(make_get(known_keys[0]));
        send_beat(make_get(known_keys[1]));
        send_beat(make_get(known_keys[0]));
        send_beat(make_publish(32'h8000_0000));
        send_beat(make_publish(32'h7fff_ffff));
        send_beat(make_publish(32'h0000_0000));
        send_beat(make_publish(32'hffff_ffff));
        send_beat(make_get(known_keys[0]));
        send_beat(make_get(known_keys[0]));
        send_beat(make_get(known_keys[1]));
        for (int k = 2; k < 8; k++)
        begin
            send_beat(make_get(known_keys[k]));
        end
        send_beat(make_get(32'h0000_0005));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            publish_pct = mix_choice[$urandom_range(0, 3)];
            if (p == PHASE_COUNT - 1)
            begin
                req_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                req_odds   = odds_choice[$urandom_range(0, 2)];
                stall_odds = odds_choice[$urandom_range(0, 2)];
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(1, 100) <= publish_pct)
                begin
                    send_beat(make_publish(pick_value()));
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    send_beat(make_get($urandom));
                end
                else
                begin
                    send_beat(make_get(known_keys[$urandom_range(0, 7)]));
                end
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
